>>> sv/svpwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types and constants of the space-vector PWM compare generator:
// field widths, register indexes, fixed-point constants of the sine series.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // default internal precisions
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned SINE_BITS_DEF  = 16;

  // field and port widths
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned DT_W        = 8;
  localparam int unsigned SECTOR_W    = 3;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned CFG_INDEX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PWM_PERIOD    = 2'd0,
    REG_DEADTIME_COMP = 2'd1,
    REG_SWAP_PHASES   = 2'd2
  } cfg_reg_t;

  // register reset values
  localparam logic [FIELD_W-1:0] PERIOD_RESET = 16'd4000;

  // modulation index of 1.0 in Q1.15
  localparam logic [FIELD_W-1:0] M_ONE = 16'd32768;

  // sector codes
  localparam logic [SECTOR_W-1:0] SECTOR_0 = 3'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
  localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;

  // Q1.30 arithmetic of the sine series
  localparam int unsigned X_W       = 31;
  localparam int unsigned Q30_SHIFT = 30;
  localparam int unsigned MAG_W     = 32;
  localparam logic [X_W-1:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [X_W-1:0] PI_BY_3_Q30 = 31'd1124419809;

  // Horner divisors, innermost term first
  localparam int unsigned HORNER_STEPS = 4;
  localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{72, 42, 20, 6};

  // the two sine arguments travel together: a is theta, b is sixty minus theta
  typedef struct packed {
    logic [X_W-1:0] a;
    logic [X_W-1:0] b;
  } ab_t;

endpackage
`default_nettype wire

>>> sv/svpwm_compare_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svpwm_compare_generator
// Centre-aligned space-vector PWM: three compare values and the sector of
// the voltage vector from modulation index, rotor angle and lead angle.
// ----------------------------------------------------------------------------
// Usage
//   s_tdata carries one update: mod_index, rotor_angle, lead_angle. Each
//   accepted transaction gives exactly one m_tdata transaction with
//   compare_a, compare_b, compare_c and sector_index, in order.
//   The cfg channel writes pwm_period (0), deadtime_comp (1) and
//   swap_phases (2); cfg_ready is always high, unknown indexes are dropped.
//   Write configuration only while no update is in flight.
//   Throughput is one update per cycle while m_tready is high or a stage is
//   empty. The sixteen-stage datapath: an input stage, then multiplier stages
//   through the angle scaling, the five-term sine series (multiply and
//   reciprocal-multiply stages) and the on-time products, then three stages
//   of null time, candidate edges, and ordering and saturation.
//   When m_tready is low, the stalled result holds and empty stages behind
//   it keep filling, so s_tready drops only once every stage holds an update.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (period 4000, no compensation, no swap); no clearing pass is needed.
// ----------------------------------------------------------------------------
module svpwm_compare_generator
  import svpwm_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned SINE_BITS  = SINE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // mod_index [15:0], rotor_angle [31:16], lead_angle [47:32]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // compare_a [15:0], compare_b [31:16], compare_c [47:32],
  // sector_index [50:48], zero [55:51]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]     cfg_data
);

  localparam int unsigned AB    = ANGLE_BITS;
  localparam int unsigned SB    = SINE_BITS;
  localparam int unsigned PW    = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;
  localparam int unsigned MP_W  = 15 + PW;
  localparam int unsigned V_W   = PW + 3;
  localparam int unsigned NS    = 16;
  localparam int unsigned PAD_W = OUT_TDATA_W - 3 * FIELD_W - SECTOR_W;
  localparam logic [AB:0] TURN  = (AB + 1)'(1) << AB;

  // stage numbers
  localparam int unsigned ST_IN   = 0;
  localparam int unsigned ST_X    = 1;
  localparam int unsigned ST_X2   = 2;
  localparam int unsigned ST_HRN  = 3;
  localparam int unsigned ST_SIN  = 11;
  localparam int unsigned ST_TON  = 12;
  localparam int unsigned ST_NULL = 13;
  localparam int unsigned ST_ADD  = 14;
  localparam int unsigned ST_OUT  = 15;

  // configuration registers
  logic [FIELD_W-1:0] pwm_period;
  logic [DT_W-1:0]    deadtime_comp;
  logic               swap_phases;
  logic [PW-1:0]      period;

  assign cfg_ready = 1'b1;
  assign period    = pwm_period[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period    <= PERIOD_RESET;
      deadtime_comp <= '0;
      swap_phases   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PWM_PERIOD:    pwm_period    <= cfg_data;
        REG_DEADTIME_COMP: deadtime_comp <= cfg_data[DT_W-1:0];
        REG_SWAP_PHASES:   swap_phases   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when it is empty or everything after it moves
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  for (genvar i = 0; i < NS; i++) begin : g_en
    localparam logic [NS-1:0] BELOW = NS'((64'd1 << i) - 64'd1);
    assign en[i] = m_tready | ~&(vld | BELOW);
  end

  assign s_tready = en[ST_IN];
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // input unpacking, angle sum and sector split
  logic [FIELD_W-1:0]        in_mod;
  logic [FIELD_W-1:0]        in_rotor;
  logic signed [FIELD_W-1:0] in_lead;
  logic [FIELD_W-1:0]        ang_sum;
  logic [AB-1:0]             ang;
  logic [AB+2:0]             ang_x6;
  logic [AB-1:0]             frac_in;

  assign in_mod   = s_tdata[0 +: FIELD_W];
  assign in_rotor = s_tdata[FIELD_W +: FIELD_W];
  assign in_lead  = s_tdata[2*FIELD_W +: FIELD_W];
  assign ang_sum  = in_rotor + FIELD_W'($unsigned(in_lead));

  if (AB >= FIELD_W) begin : g_ang_wide
    assign ang = AB'(ang_sum) << (AB - FIELD_W);
  end else begin : g_ang_narrow
    assign ang = ang_sum[FIELD_W-1 -: AB];
  end

  assign ang_x6  = ((AB + 3)'(ang) << 2) + ((AB + 3)'(ang) << 1);
  assign frac_in = ang_x6[AB-1:0];

  logic [SECTOR_W-1:0] sector_q [NS];
  logic [FIELD_W-1:0]  m_q;
  logic [AB-1:0]       frac_q;
  logic [AB:0]         gfrac_q;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      m_q         <= (in_mod > M_ONE) ? M_ONE : in_mod;
      frac_q      <= frac_in;
      gfrac_q     <= TURN - (AB + 1)'(frac_in);
    end
  end

  // sector travels alongside the datapath
  always_ff @(posedge clk) begin
    if (en[ST_IN]) sector_q[0] <= ang_x6[AB +: SECTOR_W];
    for (int k = 1; k < NS; k++) begin
      if (en[k]) sector_q[k] <= sector_q[k-1];
    end
  end

  // radian arguments and modulation times period
  logic [AB+X_W-1:0]      xa_prod;
  logic [AB+X_W:0]        xb_prod;
  logic [FIELD_W+PW-1:0]  mp_prod;
  ab_t                    x_q  [ST_X:ST_SIN-1];
  logic [MP_W-1:0]        mp_q [ST_X:ST_TON-1];

  assign xa_prod = (AB + X_W)'(frac_q) * (AB + X_W)'(PI_BY_3_Q30);
  assign xb_prod = (AB + X_W + 1)'(gfrac_q) * (AB + X_W + 1)'(PI_BY_3_Q30);
  assign mp_prod = (FIELD_W + PW)'(m_q) * (FIELD_W + PW)'(period);

  always_ff @(posedge clk) begin
    if (en[ST_X]) begin
      x_q[ST_X]  <= '{a: xa_prod[AB +: X_W], b: xb_prod[AB +: X_W]};
      mp_q[ST_X] <= MP_W'(mp_prod);
    end
    for (int k = ST_X + 1; k < ST_SIN; k++) begin
      if (en[k]) x_q[k] <= x_q[k-1];
    end
    for (int k = ST_X + 1; k < ST_TON; k++) begin
      if (en[k]) mp_q[k] <= mp_q[k-1];
    end
  end

  // squared arguments
  logic [2*X_W-1:0] x2a_prod;
  logic [2*X_W-1:0] x2b_prod;
  ab_t              x2_q [ST_X2:ST_HRN+2*HORNER_STEPS-3];

  assign x2a_prod = (2 * X_W)'(x_q[ST_X].a) * (2 * X_W)'(x_q[ST_X].a);
  assign x2b_prod = (2 * X_W)'(x_q[ST_X].b) * (2 * X_W)'(x_q[ST_X].b);

  always_ff @(posedge clk) begin
    if (en[ST_X2]) begin
      x2_q[ST_X2] <= '{a: x2a_prod[Q30_SHIFT +: X_W], b: x2b_prod[Q30_SHIFT +: X_W]};
    end
    for (int k = ST_X2 + 1; k <= ST_HRN + 2 * HORNER_STEPS - 3; k++) begin
      if (en[k]) x2_q[k] <= x2_q[k-1];
    end
  end

  // Horner series: product stage, then division by reciprocal multiply
  ab_t prod_next [HORNER_STEPS];
  ab_t prod_q    [HORNER_STEPS];
  ab_t t_next    [HORNER_STEPS];
  ab_t t_q       [HORNER_STEPS];

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
    localparam int unsigned KP    = ST_HRN + 2 * j;
    localparam int unsigned DIV   = HORNER_DIV[j];
    localparam int unsigned SH    = X_W + $clog2(DIV);
    localparam longint unsigned MAGIC =
      ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    ab_t                    t_in;
    logic [2*X_W-1:0]       pa;
    logic [2*X_W-1:0]       pb;
    logic [X_W+MAG_W-1:0]   qa;
    logic [X_W+MAG_W-1:0]   qb;

    if (j == 0) begin : g_first
      assign t_in = '{a: Q30_ONE, b: Q30_ONE};
    end else begin : g_next
      assign t_in = t_q[j-1];
    end

    assign pa = (2 * X_W)'(x2_q[KP-1].a) * (2 * X_W)'(t_in.a);
    assign pb = (2 * X_W)'(x2_q[KP-1].b) * (2 * X_W)'(t_in.b);
    assign prod_next[j] = '{a: pa[Q30_SHIFT +: X_W], b: pb[Q30_SHIFT +: X_W]};

    assign qa = (X_W + MAG_W)'(prod_q[j].a) * (X_W + MAG_W)'(MAGIC[MAG_W-1:0]);
    assign qb = (X_W + MAG_W)'(prod_q[j].b) * (X_W + MAG_W)'(MAGIC[MAG_W-1:0]);
    assign t_next[j] = '{a: Q30_ONE - X_W'(qa >> SH), b: Q30_ONE - X_W'(qb >> SH)};
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < HORNER_STEPS; j++) begin
      if (en[ST_HRN + 2 * j])     prod_q[j] <= prod_next[j];
      if (en[ST_HRN + 2 * j + 1]) t_q[j]    <= t_next[j];
    end
  end

  // final sine product, truncated to the sine precision
  logic [2*X_W-1:0] sa_prod;
  logic [2*X_W-1:0] sb_prod;
  logic [SB-1:0]    sa_q;
  logic [SB-1:0]    sb_q;

  assign sa_prod = (2 * X_W)'(x_q[ST_SIN-1].a) * (2 * X_W)'(t_q[HORNER_STEPS-1].a);
  assign sb_prod = (2 * X_W)'(x_q[ST_SIN-1].b) * (2 * X_W)'(t_q[HORNER_STEPS-1].b);

  always_ff @(posedge clk) begin
    if (en[ST_SIN]) begin
      sa_q <= sa_prod[(2 * X_W - 1 - SB) +: SB];
      sb_q <= sb_prod[(2 * X_W - 1 - SB) +: SB];
    end
  end

  // active-vector on-times
  logic [MP_W+SB-1:0] t1_prod;
  logic [MP_W+SB-1:0] t2_prod;
  logic [PW-1:0]      t1_q [ST_TON:ST_ADD-1];
  logic [PW-1:0]      t2_q [ST_TON:ST_ADD-1];

  assign t1_prod = (MP_W + SB)'(mp_q[ST_TON-1]) * (MP_W + SB)'(sb_q);
  assign t2_prod = (MP_W + SB)'(mp_q[ST_TON-1]) * (MP_W + SB)'(sa_q);

  always_ff @(posedge clk) begin
    if (en[ST_TON]) begin
      t1_q[ST_TON] <= t1_prod[(14 + SB) +: PW];
      t2_q[ST_TON] <= t2_prod[(14 + SB) +: PW];
    end
    if (en[ST_NULL]) begin
      t1_q[ST_NULL] <= t1_q[ST_TON];
      t2_q[ST_NULL] <= t2_q[ST_TON];
    end
  end

  // null time, clipped at zero, and half of it as the base value
  logic [PW:0]   on_sum;
  logic [PW:0]   null_diff;
  logic [PW:0]   sum_q;
  logic [PW-1:0] base_q;

  assign on_sum    = (PW + 1)'(t1_q[ST_TON]) + (PW + 1)'(t2_q[ST_TON]);
  assign null_diff = (on_sum > (PW + 1)'(period)) ? '0 : (PW + 1)'(period) - on_sum;

  always_ff @(posedge clk) begin
    if (en[ST_NULL]) begin
      sum_q  <= on_sum;
      base_q <= null_diff[PW:1];
    end
  end

  // the four candidate edges with dead-time compensation
  logic [V_W-1:0] v0_q;
  logic [V_W-1:0] v1_q;
  logic [V_W-1:0] v2_q;
  logic [V_W-1:0] v3_q;
  logic [V_W-1:0] base_dt;

  assign base_dt = V_W'(base_q) + V_W'(deadtime_comp);

  always_ff @(posedge clk) begin
    if (en[ST_ADD]) begin
      v0_q <= base_dt;
      v1_q <= base_dt + V_W'(t1_q[ST_NULL]);
      v2_q <= base_dt + V_W'(t2_q[ST_NULL]);
      v3_q <= base_dt + V_W'(sum_q);
    end
  end

  // sector ordering, saturation at the period and phase swap
  function automatic logic [FIELD_W-1:0] clip(input logic [V_W-1:0] v,
                                              input logic [PW-1:0]  lim);
    logic [PW-1:0] r;
    r = (v > V_W'(lim)) ? lim : v[PW-1:0];
    return FIELD_W'(r);
  endfunction

  logic [V_W-1:0]     c1;
  logic [V_W-1:0]     c2;
  logic [V_W-1:0]     c3;
  logic [FIELD_W-1:0] cmp_a;
  logic [FIELD_W-1:0] cmp_b;
  logic [FIELD_W-1:0] cmp_c;

  always_comb begin
    unique case (sector_q[ST_ADD])
      SECTOR_0: begin c1 = v0_q; c2 = v1_q; c3 = v3_q; end
      SECTOR_1: begin c1 = v2_q; c2 = v0_q; c3 = v3_q; end
      SECTOR_2: begin c1 = v3_q; c2 = v0_q; c3 = v1_q; end
      SECTOR_3: begin c1 = v3_q; c2 = v2_q; c3 = v0_q; end
      SECTOR_4: begin c1 = v1_q; c2 = v3_q; c3 = v0_q; end
      default:  begin c1 = v0_q; c2 = v3_q; c3 = v2_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      cmp_a <= clip(c1, period);
      cmp_b <= swap_phases ? clip(c3, period) : clip(c2, period);
      cmp_c <= swap_phases ? clip(c2, period) : clip(c3, period);
    end
  end

  assign m_tdata = {PAD_W'(0), sector_q[NS-1], cmp_c, cmp_b, cmp_a};

`ifndef SYNTHESIS
  // a delivered sector is always one of the six
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (sector_q[NS-1] <= SECTOR_5))
    else $error("sector index out of range");

  // with no result waiting the pipeline can always take an update
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with the output stage empty");

  // an accepted update occupies the first stage on the next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted update lost at pipeline entry");
`endif

endmodule
`default_nettype wire
